// ===== rtl/lru_key_value_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, quiet during reset.
`define LKVC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LKVC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
// Plain invariant.
`define LKVC_ASSERT_ALW(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);
`else
`define LKVC_ASSERT_IMP(label, ante, cons, msg)
`define LKVC_ASSERT_NXT(label, ante, cons, msg)
`define LKVC_ASSERT_ALW(label, cond, msg)
`endif

`endif

// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  // Read data returned on a get that misses
  localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};
  // Read data returned on any put
  localparam logic [DATA_W-1:0] READ_PUT  = '0;
  // Capacity register value after reset
  localparam logic [CFG_W-1:0]  CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_e;

  // One cache line as held in a cell
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } entry_t;

  // Sequencer strobes
  typedef struct packed {
    logic in_ready;
    logic look_en;
    logic upd_en;
  } seq_t;

endpackage

// ===== rtl/lkvc_cell.sv =====
// One cell of the recency-ordered entry chain: holds one line, compares its key.
module lkvc_cell
  import lkvc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,    // take the line of the left neighbour
  input  entry_t           left_i,
  input  logic [KEY_W-1:0] cmp_key_i,
  output entry_t           entry_o,
  output logic             match_o
);

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] value_q, value_d;

  // Next line: neighbour's line on a shift, else hold
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (shift_i) begin
      valid_d = left_i.valid;
      key_d   = left_i.key;
      value_d = left_i.value;
    end
  end

  // Valid mark is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign match_o = valid_q && (key_q == cmp_key_i);

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// LRU key-value cache: cells ordered by recency, most recent at cell 0.
// Each request is registered, compared against every cell, then committed (compare, then shift).
// The accept/compare/update sequencer takes no new item until the last one has committed.
// A stalled output holds the update; the next item may be taken while a result waits.
// Reset clears valid marks, entry count and sequencer; capacity resets to 16.
// Key and value storage is not cleared; no clearing pass is needed.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]        s_axis_tuser,   // [0] command
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] read_value
  output logic [0:0]        m_axis_tuser,   // [0] hit
  // capacity register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Sequencer
  state_e state_q, state_d;
  seq_t   seq;
  logic   commit;

  // Request
  cmd_e              req_cmd_q;
  logic [KEY_W-1:0]  req_key_q;
  logic [DATA_W-1:0] req_value_q;

  // Compare results
  logic [CAPACITY-1:0] match_vec, match_vec_q;
  logic [IW-1:0]       match_idx, match_idx_q;
  logic [DATA_W-1:0]   match_val, match_val_q;

  // Bookkeeping
  logic [CW-1:0]    count_q, count_d;
  logic [CFG_W-1:0] cap_q, cap_d;
  logic [CFG_W-1:0] cap_eff;
  logic             fill;

  // Chain
  entry_t              cell_ent [CAPACITY];
  entry_t              new_ent;
  logic [CAPACITY-1:0] shift;
  logic [CAPACITY-1:0] valid_vec;
  logic                do_shift;
  logic [CW-1:0]       stop;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  logic is_hit, is_put;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_UPD;
      ST_UPD:  if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    seq = '0;
    case (state_q)
      ST_IDLE: seq.in_ready = 1'b1;
      ST_LOOK: seq.look_en  = 1'b1;
      ST_UPD:  seq.upd_en   = 1'b1;
      default: seq = '0;
    endcase
  end

  assign s_axis_tready = seq.in_ready;
  assign commit        = seq.upd_en && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_cmd_q   <= cmd_e'(s_axis_tuser[0]);
      req_key_q   <= s_axis_tdata[31:0];
      req_value_q <= s_axis_tdata[63:32];
    end
  end

  // Cell row; cell 0 is fed the incoming line
  assign new_ent.valid = 1'b1;
  assign new_ent.key   = req_key_q;
  assign new_ent.value = (is_hit && !is_put) ? match_val_q : req_value_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left;
    if (g == 0) begin : g_head
      assign left = new_ent;
    end else begin : g_body
      assign left = cell_ent[g-1];
    end
    assign shift[g]     = commit && do_shift && (CW'(g) <= stop);
    assign valid_vec[g] = cell_ent[g].valid;
    lkvc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift[g]),
      .left_i    (left),
      .cmp_key_i (req_key_q),
      .entry_o   (cell_ent[g]),
      .match_o   (match_vec[g])
    );
  end

  // Encode the (at most one) matching cell and its value
  always_comb begin
    match_idx = '0;
    match_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        match_idx = match_idx | IW'(i);
        match_val = match_val | cell_ent[i].value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_vec_q <= '0;
    end else if (seq.look_en) begin
      match_vec_q <= match_vec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.look_en) begin
      match_idx_q <= match_idx;
      match_val_q <= match_val;
    end
  end

  // Update decision
  assign is_hit  = |match_vec_q;
  assign is_put  = (req_cmd_q == CMD_PUT);
  assign cap_eff = (cap_q == '0) ? CFG_W'(1) : cap_q;
  assign fill    = (32'(count_q) < 32'(cap_eff)) && (32'(count_q) < 32'(CAPACITY));

  always_comb begin
    do_shift = 1'b0;
    stop     = '0;
    count_d  = count_q;
    if (is_hit) begin
      // move the hit line to the front
      do_shift = 1'b1;
      stop     = CW'(match_idx_q);
    end else if (is_put) begin
      do_shift = 1'b1;
      if (fill) begin
        stop = count_q;
        if (commit) count_d = count_q + CW'(1);
      end else begin
        // least recent line drops off the tail
        stop = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Capacity register
  assign cfg_ready_o = 1'b1;
  assign cap_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_data_d  = out_data_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if (commit) begin
      out_valid_d = 1'b1;
      out_hit_d   = is_hit;
      if (is_put)      out_data_d = READ_PUT;
      else if (is_hit) out_data_d = match_val_q;
      else             out_data_d = READ_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q  <= out_hit_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tuser[0] = out_hit_q;
  assign m_axis_tdata    = out_data_q;

  // Checks
  `LKVC_ASSERT_ALW(a_count_range, 32'(count_q) <= 32'(CAPACITY), "entry count above capacity")
  `LKVC_ASSERT_ALW(a_valid_count, $countones(valid_vec) == 32'(count_q), "valid marks disagree with count")
  `LKVC_ASSERT_ALW(a_single_match, $onehot0(match_vec_q), "key present in more than one cell")
  `LKVC_ASSERT_NXT(a_accept_look, s_axis_tvalid && s_axis_tready, state_q == ST_LOOK, "accept did not start a lookup")
  `LKVC_ASSERT_IMP(a_commit_room, commit, !out_valid_q || m_axis_tready, "result overwritten before transfer")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the LRU key-value cache: predictor, driver, monitor, scoreboard.
module testbench;
  import lkvc_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_GAP     = 18;

  typedef struct {
    cmd_e              op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } cache_req_t;

  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } cache_result_t;

  // DUT connections, all inputs known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;  // [31:0] key, [63:32] value
  logic [0:0]        s_axis_tuser  = '0;  // [0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [31:0] read_value
  logic [0:0]        m_axis_tuser;        // [0] hit
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i    = '0;

  lru_key_value_cache #(
    .CAPACITY(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the cache contents
  logic [KEY_W-1:0]  shadow_key   [SLOTS];
  logic [DATA_W-1:0] shadow_value [SLOTS];
  logic              shadow_live  [SLOTS];
  int                shadow_age   [SLOTS];
  int                live_count   = 0;
  logic [CFG_W-1:0]  capacity_reg = CAP_RESET;

  cache_req_t    pending_reqs[$];
  cache_result_t expected_results[$];
  cache_req_t    current_req;
  cache_req_t    next_req;
  logic [KEY_W-1:0] key_pool [32];

  int in_pace, out_pace;
  int send_gap, stall_left;
  int error_count, cycle_count, accepted_reqs, checked_results, cfg_writes;
  int n_get_hit, n_get_miss, n_put_hit, n_insert, n_evict;

  function automatic int draw_gap(int pace);
    case (pace)
      0:       return 0;
      1:       return $urandom_range(0, MAX_GAP);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  // Zero and oversize settings are clamped
  function automatic int usable_capacity();
    int c;
    c = capacity_reg;
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  // Entry idx becomes most recent; everything fresher than it ages by one
  function automatic void promote_entry(int idx, int old_age);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_live[i] && i != idx && shadow_age[i] < old_age) shadow_age[i]++;
    end
    shadow_age[idx] = 0;
  endfunction

  // Look up, update the shadow cache and return the response for one request
  function automatic cache_result_t access_cache(cache_req_t req);
    cache_result_t res;
    int match, slot, victim, oldest;
    match  = -1;
    slot   = -1;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match < 0 && shadow_live[i] && shadow_key[i] == req.key) match = i;
    end
    if (match >= 0) begin
      res.hit = 1'b1;
      if (req.op == CMD_GET) begin
        res.read_value = shadow_value[match];
        n_get_hit++;
      end else begin
        shadow_value[match] = req.value;
        res.read_value      = READ_PUT;
        n_put_hit++;
      end
      promote_entry(match, shadow_age[match]);
      return res;
    end
    res.hit = 1'b0;
    if (req.op == CMD_GET) begin
      res.read_value = READ_MISS;
      n_get_miss++;
      return res;
    end
    res.read_value = READ_PUT;
    // fill the lowest free entry while under capacity
    if (live_count < usable_capacity()) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !shadow_live[i]) slot = i;
      end
    end
    if (slot >= 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_live[i]) shadow_age[i]++;
      end
      shadow_live[slot]  = 1'b1;
      shadow_key[slot]   = req.key;
      shadow_value[slot] = req.value;
      shadow_age[slot]   = 0;
      live_count++;
      n_insert++;
      return res;
    end
    // otherwise replace the oldest; ties go to the highest index
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_live[i] && (victim < 0 || shadow_age[i] >= oldest)) begin
        victim = i;
        oldest = shadow_age[i];
      end
    end
    if (victim >= 0) begin
      shadow_key[victim]   = req.key;
      shadow_value[victim] = req.value;
      promote_entry(victim, oldest);
      n_evict++;
    end
    return res;
  endfunction

  // Request driver: one queued request per transfer, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(access_cache(current_req));
        accepted_reqs++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req         = pending_reqs.pop_front();
          current_req     <= next_req;
          s_axis_tdata    <= {next_req.value, next_req.key};
          s_axis_tuser[0] <= next_req.op;
          s_axis_tvalid   <= 1'b1;
          send_gap        <= draw_gap(in_pace);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare each transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected response: hit=%0b read_value=%h", m_axis_tuser[0], m_axis_tdata);
          error_count++;
        end else begin
          exp = expected_results.pop_front();
          checked_results++;
          if (m_axis_tuser[0] !== exp.hit) begin
            $error("hit: expected %0b, got %0b", exp.hit, m_axis_tuser[0]);
            error_count++;
          end
          if (m_axis_tdata !== exp.read_value) begin
            $error("read_value: expected %h, got %h", exp.read_value, m_axis_tdata);
            error_count++;
          end
        end
        stall_left    <= draw_gap(out_pace);
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout with %0d requests queued and %0d responses outstanding",
             pending_reqs.size(), expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_req(cmd_e op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
    cache_req_t req;
    req.op    = op;
    req.key   = key;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Capacity writes only with the cache idle
  task automatic write_capacity(logic [CFG_W-1:0] cap);
    wait_drained();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity_reg = cap;
    cfg_writes++;
  endtask

  // Random mix drawn mostly from a small key pool so that hits and evictions are common
  task automatic queue_random_mix(int count, int span);
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 6) == 0) key = $urandom();
      else key = key_pool[$urandom_range(0, span - 1)];
      queue_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, $urandom());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] caps [9];
    int span;
    caps = '{5'd16, 5'd31, 5'd1, 5'd3, 5'd9, 5'd2, 5'd17, 5'd0, 5'd0};
    caps[8] = $urandom_range(0, 31);
    for (int i = 0; i < SLOTS; i++) begin
      shadow_live[i] = 1'b0;
      shadow_age[i]  = 0;
    end
    in_pace  = 1;
    out_pace = 2;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty lookup, extreme keys and values, overwrite, miss
    queue_req(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_req(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    queue_req(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(CMD_GET, 32'h0000_0001, 32'h0000_0000);

    // Directed: zero capacity behaves as one, and sits below the live count
    write_capacity(5'd0);
    queue_req(CMD_PUT, 32'h0000_0005, 32'hAAAA_5555);
    queue_req(CMD_PUT, 32'h0000_0006, 32'h5555_AAAA);
    queue_req(CMD_GET, 32'h0000_0005, 32'h0000_0000);
    queue_req(CMD_GET, 32'h0000_0006, 32'h0000_0000);
    queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);

    // Random phases across capacity settings and idling patterns
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      in_pace  = p % 3;
      out_pace = (p + 1) % 3;
      foreach (key_pool[i]) key_pool[i] = $urandom();
      span = usable_capacity() + $urandom_range(1, 8);
      queue_random_mix(70, span);
      // hold the sender until every response is back
      wait_drained();
      queue_random_mix(70, span);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("%0d requests checked over %0d capacity writes (top setting 31, bottom 0)",
             checked_results, cfg_writes);
    $display("get hit %0d, get miss %0d, put update %0d, insert %0d, eviction %0d",
             n_get_hit, n_get_miss, n_put_hit, n_insert, n_evict);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
